@@ hw/rtl/skf_pkg.sv @@
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants of the scalar Kalman filter.
// ----------------------------------------------------------------------------
package skf_pkg;

  // q16.16 and q1.16 fixed point
  localparam int VAR_FRAC = 16;
  localparam logic [16:0] GAIN_ONE = 17'd65536;
  localparam logic [31:0] VAR_ONE = 32'd65536;
  localparam logic [31:0] PRED_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] Q_RESET = 32'd655;
  localparam logic [31:0] R_RESET = 32'd65536;

  // one quotient bit per step, 17 bits of gain
  localparam int DIV_STEPS = 17;
  localparam int CNT_W = 5;

  // configuration space
  localparam int ADDR_W = 3;
  localparam logic REG_PROCESS_NOISE = 1'b0;
  localparam logic REG_MEASUREMENT_NOISE = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic prep;
    logic div_step;
    logic div_first;
    logic mul;
    logic update;
  } skf_cmd_t;

endpackage

@@ hw/rtl/skf_sample_if.sv @@
// ----------------------------------------------------------------------------
// skf_sample_if
// Measurement channel: valid/ready handshake with one signed sample.
// ----------------------------------------------------------------------------
interface skf_sample_if;
  logic valid;
  logic ready;
  logic signed [15:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink (input valid, input measurement, output ready);
endinterface

@@ hw/rtl/skf_result_if.sv @@
// ----------------------------------------------------------------------------
// skf_result_if
// Result channel: valid/ready handshake with estimate, gain and flag.
// ----------------------------------------------------------------------------
interface skf_result_if;
  logic valid;
  logic ready;
  logic signed [31:0] estimate;
  logic [16:0] gain;
  logic degenerate;

  modport source (output valid, output estimate, output gain, output degenerate,
                  input ready);
  modport sink (input valid, input estimate, input gain, input degenerate,
                output ready);
endinterface

@@ hw/rtl/skf_regs.sv @@
// ----------------------------------------------------------------------------
// skf_regs
// APB-style register file holding the noise covariances Q and R.
// ----------------------------------------------------------------------------
module skf_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [skf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [31:0]                process_noise,
  output logic [31:0]                measurement_noise,
  output logic                       cfg_write
);

  logic reg_sel;

  assign pready = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= skf_pkg::Q_RESET;
      measurement_noise <= skf_pkg::R_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        skf_pkg::REG_PROCESS_NOISE: process_noise <= pwdata;
        skf_pkg::REG_MEASUREMENT_NOISE: measurement_noise <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      skf_pkg::REG_PROCESS_NOISE: prdata = process_noise;
      skf_pkg::REG_MEASUREMENT_NOISE: prdata = measurement_noise;
      default: prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/skf_ctrl.sv @@
// ----------------------------------------------------------------------------
// skf_ctrl
// Sequencer: accept, prepare, 17 divide steps, multiply, update.
// ----------------------------------------------------------------------------
module skf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output skf_pkg::skf_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_UPD  = 3'd4;
  localparam logic [skf_pkg::CNT_W-1:0] DIV_LAST = skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1);

  logic [2:0] state;
  logic [2:0] state_next;
  logic [skf_pkg::CNT_W-1:0] div_cnt;
  logic out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = ~out_valid | out_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_first = (div_cnt == '0);
        if (div_cnt == DIV_LAST) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        // hold the finished step until the output register is free
        cmd.update = out_free;
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      div_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DIV) div_cnt <= div_cnt + 1'b1;
      else div_cnt <= '0;
      out_valid <= cmd.update | (out_valid & ~out_ready);
    end
  end

  a_accept_to_prep: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> state == ST_PREP)
    else $error("accepted sample did not start preparation");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> div_cnt <= DIV_LAST)
    else $error("divide step counter overran");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");

endmodule

@@ hw/rtl/skf_dp.sv @@
// ----------------------------------------------------------------------------
// skf_dp
// Datapath: predicted variance, restoring gain divider, estimate and
// variance update, result register.
// ----------------------------------------------------------------------------
module skf_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  skf_pkg::skf_cmd_t   cmd,
  input  logic                restart,
  input  logic [31:0]         process_noise,
  input  logic [31:0]         measurement_noise,
  input  logic signed [15:0]  measurement,
  output logic signed [31:0]  estimate,
  output logic [16:0]         gain,
  output logic                degenerate
);

  localparam int MW = 16 + FRAC_BITS;
  localparam int DW = ((MW > 32) ? MW : 32) + 1;
  localparam int PW = DW + 18;
  localparam int SW = DW + 1;

  logic signed [15:0] meas_q;
  logic signed [31:0] est_q;
  logic [31:0] var_q;
  logic [31:0] pred_q;
  logic [32:0] den_q;
  logic den_zero_q;
  logic [33:0] rem_q;
  logic [16:0] gain_q;
  logic [16:0] gain_used_q;
  logic signed [DW-1:0] diff_q;
  logic signed [PW-1:0] prod_est_q;
  logic [48:0] prod_var_q;

  logic [32:0] pred_sum;
  logic [32:0] den_sum;
  logic signed [DW-1:0] target;
  logic signed [DW-1:0] est_ext;
  logic [33:0] trial;
  logic [33:0] den_ext;
  logic trial_ge;
  logic [16:0] gain_eff;
  logic [16:0] one_minus;
  logic signed [SW-1:0] delta;
  logic signed [SW-1:0] est_wide;
  logic est_fits;
  logic signed [31:0] est_sat;

  assign pred_sum = {1'b0, var_q} + {1'b0, process_noise};
  assign den_sum = {1'b0, pred_q} + {1'b0, measurement_noise};
  assign target = {{(DW-MW){meas_q[15]}}, meas_q, {FRAC_BITS{1'b0}}};
  assign est_ext = {{(DW-32){est_q[31]}}, est_q};

  // restoring division: first step compares pred itself, later steps shift
  assign trial = cmd.div_first ? rem_q : {rem_q[32:0], 1'b0};
  assign den_ext = {1'b0, den_q};
  assign trial_ge = (trial >= den_ext);

  assign gain_eff = den_zero_q ? 17'd0 : gain_q;
  assign one_minus = skf_pkg::GAIN_ONE - gain_eff;

  // floor shift by the gain's fraction bits
  assign delta = prod_est_q[skf_pkg::VAR_FRAC +: SW];
  assign est_wide = {{(SW-32){est_q[31]}}, est_q} + delta;
  assign est_fits = (est_wide[SW-1:31] == '0) || (est_wide[SW-1:31] == '1);
  assign est_sat = est_fits ? est_wide[31:0]
                 : (est_wide[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      est_q <= '0;
      var_q <= skf_pkg::VAR_ONE;
    end else if (cmd.update) begin
      est_q <= est_sat;
      var_q <= prod_var_q[47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      meas_q <= measurement;
      pred_q <= pred_sum[32] ? skf_pkg::PRED_MAX : pred_sum[31:0];
    end
    if (cmd.prep) begin
      den_q <= den_sum;
      den_zero_q <= (den_sum == '0);
      rem_q <= {2'b00, pred_q};
      gain_q <= '0;
      diff_q <= target - est_ext;
    end
    if (cmd.div_step) begin
      rem_q <= trial_ge ? (trial - den_ext) : trial;
      gain_q <= {gain_q[15:0], trial_ge};
    end
    if (cmd.mul) begin
      gain_used_q <= gain_eff;
      prod_est_q <= $signed({1'b0, gain_eff}) * diff_q;
      prod_var_q <= {32'b0, one_minus} * {17'b0, pred_q};
    end
    if (cmd.update) begin
      estimate <= est_sat;
      gain <= gain_used_q;
      degenerate <= den_zero_q;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> rem_q <= {1'b0, den_q})
    else $error("divider remainder exceeds denominator");

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.mul && !den_zero_q |-> gain_q <= skf_pkg::GAIN_ONE)
    else $error("gain above one");

  a_degen_gain: assert property (@(posedge clk) disable iff (rst)
    cmd.update && den_zero_q |-> gain_used_q == 17'd0)
    else $error("zero denominator with nonzero gain");

endmodule

@@ hw/rtl/scalar_kalman_filter_top.sv @@
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top
// One-dimensional constant-state Kalman filter with APB configuration.
// Each sample passes through the prepare, 17-step gain divide, multiply and
// update states; no new sample is accepted until its update is done.
// The next sample is taken while a finished result still waits.
// Reset (rst, synchronous): Q = 655, R = 1.0, estimate 0, variance 1.0;
// any register write also restarts estimate and variance.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [skf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  skf_sample_if.sink                 sample,
  skf_result_if.source               result
);

  logic [31:0] process_noise;
  logic [31:0] measurement_noise;
  logic cfg_write;
  skf_pkg::skf_cmd_t cmd;

  skf_regs u_regs (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .process_noise     (process_noise),
    .measurement_noise (measurement_noise),
    .cfg_write         (cfg_write)
  );

  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  skf_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .restart           (cfg_write),
    .process_noise     (process_noise),
    .measurement_noise (measurement_noise),
    .measurement       (sample.measurement),
    .estimate          (result.estimate),
    .gain              (result.gain),
    .degenerate        (result.degenerate)
  );

endmodule
